### hdl/gn2_pkg.sv
package gn2_pkg;

	// Default number of fraction bits on the coordinates.
	localparam int FRAC_BITS_DEF = 16;

	// Permutation table geometry.
	localparam int TBL_AW = 8;
	localparam int TBL_DW = 8;

	// Kind of an input beat, carried in tuser.
	typedef enum logic {
		ACT_EVAL  = 1'b0,
		ACT_WRITE = 1'b1
	} action_t;

	// Gradient hash codes that steer the corner dot product.
	localparam logic [3:0] GRAD_U_FROM_Y = 4'd8;
	localparam logic [3:0] GRAD_V_FROM_Y = 4'd4;
	localparam logic [3:0] GRAD_V_X_A    = 4'd12;
	localparam logic [3:0] GRAD_V_X_B    = 4'd14;

	// Output format.
	localparam int OUT_FRAC = 16;
	localparam int OUT_W    = 18;

endpackage

### hdl/gn2_ram.sv
module gn2_ram
	import gn2_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [TBL_AW-1:0] waddr,
	input  logic [TBL_DW-1:0] wdata,
	input  logic              re,
	input  logic [TBL_AW-1:0] raddr0,
	input  logic [TBL_AW-1:0] raddr1,
	output logic [TBL_DW-1:0] rdata0,
	output logic [TBL_DW-1:0] rdata1
);

	logic [TBL_DW-1:0] mem [2**TBL_AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while the pipeline is stalled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

### hdl/gn2_fade.sv
module gn2_fade
	import gn2_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] frac,
	output logic [FRAC_BITS:0]   fade
);

	localparam int F = FRAC_BITS;
	localparam logic [F+3:0] ONE15 = (F+4)'(15) << F;
	localparam logic [F+3:0] ONE10 = (F+4)'(10) << F;

	logic [F+3:0]   coef;
	logic [2*F+3:0] qprod;
	logic [2*F-1:0] sq_s1;
	logic [F+3:0]   q_s1;
	logic [F-1:0]   f_s1;
	logic [2*F-1:0] cube;
	logic [F-1:0]   t3_s2;
	logic [F+3:0]   s_s2;
	logic [2*F+3:0] fprod;

	// 15 - 6f, then f * (15 - 6f).
	assign coef  = ONE15 - (F+4)'((F+4)'(frac) * (F+4)'(6));
	assign qprod = (2*F+4)'(frac) * (2*F+4)'(coef);
	assign cube  = (2*F)'(sq_s1[2*F-1:F]) * (2*F)'(f_s1);
	assign fprod = (2*F+4)'(t3_s2) * (2*F+4)'(s_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= (2*F)'(frac) * (2*F)'(frac);
			q_s1  <= qprod[2*F+3:F];
			f_s1  <= frac;
			t3_s2 <= cube[2*F-1:F];
			s_s2  <= ONE10 - q_s1;
			fade  <= fprod[2*F:F];
		end
	end

endmodule

### hdl/gradient_noise_2d_core.sv
// Channel  | Dir | tdata fields (low bit up)                              | tuser
// s_axis   | in  | x_coord[31:0] y_coord[63:32] table_index[71:64]       | action
//          |     | table_value[79:72]                                     |
// m_axis   | out | noise_value[17:0], zero filled to 24 bits              | none
//
// While the skid register is empty, throughput is one beat per cycle for runs
// of evaluate beats or runs of write beats. A write beat that directly follows
// evaluate beats waits until those have done their table lookups. An evaluate
// beat passes through stages s1 to s7 before it reaches the output register;
// the three dependent table reads and the fade and blend multipliers fill them.
// Reset clears only control state; the table is undefined until written.
// The output has a skid register, so one result may wait for the sink while
// the pipeline keeps moving; a second waiting result stalls the pipeline.
module gradient_noise_2d_core
	import gn2_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// x_coord, y_coord, table_index, table_value from the lowest bit up
	input  logic [79:0] s_tdata,
	// action
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// noise_value, then zero fill
	output logic [23:0] m_tdata
);

	localparam int F  = FRAC_BITS;
	localparam int DW = F + 3;
	localparam int VW = F + 21;
	localparam logic signed [F+1:0] ONE_D = (F+2)'(1) << F;

	// Input fields.
	logic signed [31:0] x_coord, y_coord;
	logic [7:0]         table_index, table_value;
	action_t            action;

	assign x_coord     = s_tdata[31:0];
	assign y_coord     = s_tdata[63:32];
	assign table_index = s_tdata[71:64];
	assign table_value = s_tdata[79:72];
	assign action      = action_t'(s_tuser[0]);

	logic en, write_acc, eval_acc;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic out_v_q, skid_v_q;

	// The whole pipeline moves unless the skid register is occupied.
	assign en = !skid_v_q;

	// A write may not land while an evaluate beat still has lookups to do.
	assign s_tready  = en && !(action == ACT_WRITE && (v_s1 || v_s2));
	assign write_acc = s_tvalid && s_tready && action == ACT_WRITE;
	assign eval_acc  = s_tvalid && s_tready && action == ACT_EVAL;

	// Table lookups: five copies of the permutation table, all written together.
	logic [7:0] cx, cy, cx1;
	logic [7:0] p_cx, p_cx1;
	logic [7:0] cy_s1, a_sum, b_sum;
	logic [7:0] pa, pa1, pb, pb1;
	logic [7:0] haa, hab, hba, hbb;

	assign cx  = x_coord[F+7:F];
	assign cy  = y_coord[F+7:F];
	assign cx1 = cx + 8'd1;

	gn2_ram u_ram_l1 (
		.clk(clk), .we(write_acc), .waddr(table_index), .wdata(table_value),
		.re(en), .raddr0(cx), .raddr1(cx1), .rdata0(p_cx), .rdata1(p_cx1)
	);

	assign a_sum = p_cx + cy_s1;
	assign b_sum = p_cx1 + cy_s1;

	gn2_ram u_ram_l2a (
		.clk(clk), .we(write_acc), .waddr(table_index), .wdata(table_value),
		.re(en), .raddr0(a_sum), .raddr1(a_sum + 8'd1), .rdata0(pa), .rdata1(pa1)
	);

	gn2_ram u_ram_l2b (
		.clk(clk), .we(write_acc), .waddr(table_index), .wdata(table_value),
		.re(en), .raddr0(b_sum), .raddr1(b_sum + 8'd1), .rdata0(pb), .rdata1(pb1)
	);

	gn2_ram u_ram_l3a (
		.clk(clk), .we(write_acc), .waddr(table_index), .wdata(table_value),
		.re(en), .raddr0(pa), .raddr1(pa1), .rdata0(haa), .rdata1(hab)
	);

	gn2_ram u_ram_l3b (
		.clk(clk), .we(write_acc), .waddr(table_index), .wdata(table_value),
		.re(en), .raddr0(pb), .raddr1(pb1), .rdata0(hba), .rdata1(hbb)
	);

	// Fade weights, ready in the same stage as the corner hashes.
	logic [F:0] wx_s3, wy_s3;

	gn2_fade #(.FRAC_BITS(F)) u_fade_x (
		.clk(clk), .en(en), .frac(x_coord[F-1:0]), .fade(wx_s3)
	);

	gn2_fade #(.FRAC_BITS(F)) u_fade_y (
		.clk(clk), .en(en), .frac(y_coord[F-1:0]), .fade(wy_s3)
	);

	// Gradient dot product for one corner; the offsets are exact.
	function automatic logic signed [DW-1:0] corner_dot(
		input logic [3:0] h,
		input logic signed [F+1:0] dx,
		input logic signed [F+1:0] dy
	);
		logic signed [DW-1:0] u, v;
		begin
			u = (h < GRAD_U_FROM_Y) ? DW'(dx) : DW'(dy);
			if (h < GRAD_V_FROM_Y) begin
				v = DW'(dy);
			end else if (h inside {GRAD_V_X_A, GRAD_V_X_B}) begin
				v = DW'(dx);
			end else begin
				v = '0;
			end
			corner_dot = (h[0] ? -u : u) + (h[1] ? -v : v);
		end
	endfunction

	logic [F-1:0] fx_s1, fy_s1, fx_s2, fy_s2, fx_s3, fy_s3;
	logic signed [F+1:0] dx0, dy0, dx1, dy1;

	assign dx0 = (F+2)'(fx_s3);
	assign dy0 = (F+2)'(fy_s3);
	assign dx1 = dx0 - ONE_D;
	assign dy1 = dy0 - ONE_D;

	logic signed [DW-1:0]    daa_s4, dab_s4, dba_s4, dbb_s4;
	logic [F:0]              wx_s4, wy_s4, wy_s5, wy_s6;
	logic signed [DW:0]      dlo, dhi;
	logic signed [2*F+5:0]   mlo_s5, mhi_s5;
	logic signed [DW-1:0]    daa_s5, dab_s5;
	logic signed [F+3:0]     lo_s6, hi_s6, lo_s7;
	logic signed [F+4:0]     dhl;
	logic signed [2*F+6:0]   prod_s7;
	logic signed [F+4:0]     v_fin;

	assign dlo = (DW+1)'(dba_s4) - (DW+1)'(daa_s4);
	assign dhi = (DW+1)'(dbb_s4) - (DW+1)'(dab_s4);
	assign dhl = (F+5)'(hi_s6) - (F+5)'(lo_s6);
	assign v_fin = (F+5)'(lo_s7) + (F+5)'(prod_s7 >>> F);

	always_ff @(posedge clk) begin
		if (en) begin
			cy_s1  <= cy;
			fx_s1  <= x_coord[F-1:0];
			fy_s1  <= y_coord[F-1:0];
			fx_s2  <= fx_s1;
			fy_s2  <= fy_s1;
			fx_s3  <= fx_s2;
			fy_s3  <= fy_s2;
			daa_s4 <= corner_dot(haa[3:0], dx0, dy0);
			dba_s4 <= corner_dot(hba[3:0], dx1, dy0);
			dab_s4 <= corner_dot(hab[3:0], dx0, dy1);
			dbb_s4 <= corner_dot(hbb[3:0], dx1, dy1);
			wx_s4  <= wx_s3;
			wy_s4  <= wy_s3;
			mlo_s5 <= (2*F+6)'(dlo) * (2*F+6)'($signed({1'b0, wx_s4}));
			mhi_s5 <= (2*F+6)'(dhi) * (2*F+6)'($signed({1'b0, wx_s4}));
			daa_s5 <= daa_s4;
			dab_s5 <= dab_s4;
			wy_s5  <= wy_s4;
			lo_s6  <= (F+4)'(daa_s5) + (F+4)'(mlo_s5 >>> F);
			hi_s6  <= (F+4)'(dab_s5) + (F+4)'(mhi_s5 >>> F);
			wy_s6  <= wy_s5;
			prod_s7 <= (2*F+7)'(dhl) * (2*F+7)'($signed({1'b0, wy_s6}));
			lo_s7  <= lo_s6;
		end
	end

	// Bring the blend to sixteen fraction bits, then saturate.
	logic signed [VW-1:0] v_ext, v_scaled;
	logic [OUT_W-1:0]     noise_fin;

	assign v_ext = VW'(v_fin);

	generate
		if (F > OUT_FRAC) begin : g_round
			localparam int SH = F - OUT_FRAC;
			localparam logic signed [VW-1:0] RND = VW'(1) << (SH - 1);
			assign v_scaled = (v_ext + RND) >>> SH;
		end else if (F < OUT_FRAC) begin : g_widen
			assign v_scaled = v_ext <<< (OUT_FRAC - F);
		end else begin : g_same
			assign v_scaled = v_ext;
		end
	endgenerate

	localparam logic signed [VW-1:0] SAT_HI = VW'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [VW-1:0] SAT_LO = -VW'(1 << (OUT_W - 1));

	always_comb begin
		if (v_scaled > SAT_HI) begin
			noise_fin = SAT_HI[OUT_W-1:0];
		end else if (v_scaled < SAT_LO) begin
			noise_fin = SAT_LO[OUT_W-1:0];
		end else begin
			noise_fin = v_scaled[OUT_W-1:0];
		end
	end

	// Stage valid bits, only for evaluate beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= eval_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Output register with a skid register behind it.
	logic [OUT_W-1:0] out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (v_s7) begin
				if (!out_v_q || m_tready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end else if (m_tready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s7) begin
				if (!out_v_q || m_tready) begin
					out_q <= noise_fin;
				end else begin
					skid_q <= noise_fin;
				end
			end
		end else if (m_tready) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(24 - OUT_W)'(0), out_q};

	// A write never lands while an evaluate beat still reads the table.
	a_write_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		write_acc |-> !v_s1 && !v_s2)
		else $error("table write overlaps pending lookups");

	// The skid register only holds a result behind a waiting output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register filled without output result");

	// The skid register fills only when the sink held off a result.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid register filled while sink was ready");

endmodule
